FILE: rtl/core/pitb_pkg.sv
// ----------------------------------------------------------------------------
// pitb_pkg
// Shared widths, types and codes for the barycentric point-in-triangle pipeline
// ----------------------------------------------------------------------------
package pitb_pkg;

  localparam int CW   = 16;                 // coordinate width
  localparam int FRAC = 16;                 // weight fraction bits
  localparam int EW   = 16;                 // tolerance register width
  localparam int WW   = 24;                 // weight width
  localparam int QB   = WW - 1;             // quotient bits below saturation

  localparam int DW   = CW + 1;             // coordinate differences
  localparam int NW   = 2 * DW + 1;         // cross product components
  localparam int SW   = 2 * NW + 2;         // dot products and sums
  localparam int HS   = SW / 2;             // split point for wide products
  localparam int E2W  = 2 * EW;             // squared tolerances
  localparam int DPW  = DW + NW + 2;        // plane distance numerator
  localparam int DH   = DPW / 2;
  localparam int CMPW = ((2 * DPW > E2W + SW) ? 2 * DPW : E2W + SW) + 1;
  localparam int SQW  = CMPW + 1;
  localparam int IEW  = EW + SW + 1;        // slack term
  localparam int SLW  = IEW + 1;
  localparam int RW   = SW + QB + 1;        // divider remainder

  localparam int FRONT_LAT = 8;
  localparam int DIV_LAT   = QB + 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEGEN_EPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_EPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_EPS = 2'd2;

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0]    coord_t;
  typedef logic signed [DW-1:0]    diff_t;
  typedef logic signed [2*DW-1:0]  prod_t;
  typedef logic signed [NW-1:0]    vec_t;
  typedef logic signed [2*NW-1:0]  pp_t;
  typedef logic signed [SW-1:0]    wide_t;
  typedef logic        [EW-1:0]    eps_t;
  typedef logic signed [WW-1:0]    weight_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_OFFPLANE = 2'd2
  } status_t;

  typedef struct packed {
    logic    vld;
    status_t status;
    logic    in_tri;
  } tag_t;

  typedef struct packed {
    status_t status;
    logic    in_tri;
    weight_t wa;
    weight_t wb;
    weight_t wc;
  } res_t;

endpackage

FILE: rtl/core/pitb_front.sv
// ----------------------------------------------------------------------------
// pitb_front
// Edge vectors, normal, dot products and the degeneracy, plane and inside tests
// ----------------------------------------------------------------------------
module pitb_front import pitb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  coord_t pt [3],
  input  coord_t va [3],
  input  coord_t vb [3],
  input  coord_t vc [3],
  input  eps_t   deg_eps,
  input  eps_t   plane_eps,
  input  eps_t   inside_eps,
  output tag_t   tag,
  output wide_t  num [3],
  output wide_t  nsq
);

  logic [FRONT_LAT-2:0] vld_r;

  // s1
  diff_t ab_r [3], ac_r [3], ap_r [3];
  // s2
  prod_t nl_r [3], nr_r [3], ul_r [3], ur_r [3], sl_r [3], sr_r [3];
  prod_t qb_r [3], qc_r [3];
  diff_t ap2_r [3];
  // s3
  vec_t  n_r [3], u_r [3], s_r [3];
  vec_t  abab_r, acac_r;
  diff_t ap3_r [3];
  // s4
  pp_t   nn_r [3], nd_r [3], nu_r [3], ns_r [3];
  pp_t   abac_r;
  logic [E2W-1:0] e2_r, p2_r;
  // s5
  wide_t nsq5_r, d5_r, num1_5_r, num2_5_r;
  logic [SW-1:0]  abac5_r;
  logic [E2W-1:0] e2_5_r, p2_5_r;
  // s6
  wide_t nsq6_r, num0_6_r, num1_6_r, num2_6_r;
  logic [E2W+HS-1:0] ea_lo_r, ea_hi_r, pn_lo_r, pn_hi_r;
  logic [EW+HS-1:0]  in_lo_r, in_hi_r;
  logic signed [2*(DPW-DH)-1:0] dhh_r;
  logic signed [DPW+1:0]        dhl_r;
  logic [2*DH-1:0]              dll_r;
  // s7
  wide_t nsq7_r, num0_7_r, num1_7_r, num2_7_r;
  logic [CMPW-1:0] rhs_d_r, rhs_p_r;
  logic [IEW-1:0]  iens_r;
  logic signed [SQW-1:0] dsq_r;
  // s8
  tag_t  tag_r, tag_nxt;
  wide_t nsq8_r, num8_r [3];

  logic signed [SLW-1:0] slk [3];
  logic                  degen, offplane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tag_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRONT_LAT-3:0], in_vld};
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // s1
        ab_r[i] <= diff_t'(vb[i]) - diff_t'(va[i]);
        ac_r[i] <= diff_t'(vc[i]) - diff_t'(va[i]);
        ap_r[i] <= diff_t'(pt[i]) - diff_t'(va[i]);
        // s2
        nl_r[i]  <= ab_r[NXT[i]] * ac_r[PRV[i]];
        nr_r[i]  <= ab_r[PRV[i]] * ac_r[NXT[i]];
        ul_r[i]  <= ap_r[NXT[i]] * ac_r[PRV[i]];
        ur_r[i]  <= ap_r[PRV[i]] * ac_r[NXT[i]];
        sl_r[i]  <= ab_r[NXT[i]] * ap_r[PRV[i]];
        sr_r[i]  <= ab_r[PRV[i]] * ap_r[NXT[i]];
        qb_r[i]  <= ab_r[i] * ab_r[i];
        qc_r[i]  <= ac_r[i] * ac_r[i];
        ap2_r[i] <= ap_r[i];
        // s3
        n_r[i]   <= vec_t'(nl_r[i]) - vec_t'(nr_r[i]);
        u_r[i]   <= vec_t'(ul_r[i]) - vec_t'(ur_r[i]);
        s_r[i]   <= vec_t'(sl_r[i]) - vec_t'(sr_r[i]);
        ap3_r[i] <= ap2_r[i];
        // s4
        nn_r[i]  <= n_r[i] * n_r[i];
        nd_r[i]  <= ap3_r[i] * n_r[i];
        nu_r[i]  <= n_r[i] * u_r[i];
        ns_r[i]  <= n_r[i] * s_r[i];
      end
      abab_r <= vec_t'(qb_r[0]) + vec_t'(qb_r[1]) + vec_t'(qb_r[2]);
      acac_r <= vec_t'(qc_r[0]) + vec_t'(qc_r[1]) + vec_t'(qc_r[2]);
      abac_r <= abab_r * acac_r;
      e2_r   <= deg_eps * deg_eps;
      p2_r   <= plane_eps * plane_eps;

      // s5
      nsq5_r   <= SW'(nn_r[0]) + SW'(nn_r[1]) + SW'(nn_r[2]);
      d5_r     <= SW'(nd_r[0]) + SW'(nd_r[1]) + SW'(nd_r[2]);
      num1_5_r <= SW'(nu_r[0]) + SW'(nu_r[1]) + SW'(nu_r[2]);
      num2_5_r <= SW'(ns_r[0]) + SW'(ns_r[1]) + SW'(ns_r[2]);
      abac5_r  <= SW'(abac_r);
      e2_5_r   <= e2_r;
      p2_5_r   <= p2_r;

      // s6
      nsq6_r   <= nsq5_r;
      num0_6_r <= nsq5_r - num1_5_r - num2_5_r;
      num1_6_r <= num1_5_r;
      num2_6_r <= num2_5_r;
      ea_lo_r  <= e2_5_r * abac5_r[HS-1:0];
      ea_hi_r  <= e2_5_r * abac5_r[SW-1:HS];
      pn_lo_r  <= p2_5_r * nsq5_r[HS-1:0];
      pn_hi_r  <= p2_5_r * nsq5_r[SW-1:HS];
      in_lo_r  <= inside_eps * nsq5_r[HS-1:0];
      in_hi_r  <= inside_eps * nsq5_r[SW-1:HS];
      dhh_r    <= $signed(d5_r[DPW-1:DH]) * $signed(d5_r[DPW-1:DH]);
      dhl_r    <= $signed(d5_r[DPW-1:DH]) * $signed({1'b0, d5_r[DH-1:0]});
      dll_r    <= d5_r[DH-1:0] * d5_r[DH-1:0];

      // s7
      nsq7_r   <= nsq6_r;
      num0_7_r <= num0_6_r;
      num1_7_r <= num1_6_r;
      num2_7_r <= num2_6_r;
      rhs_d_r  <= (CMPW'(ea_hi_r) << HS) + CMPW'(ea_lo_r);
      rhs_p_r  <= (CMPW'(pn_hi_r) << HS) + CMPW'(pn_lo_r);
      iens_r   <= (IEW'(in_hi_r) << HS) + IEW'(in_lo_r);
      dsq_r    <= (SQW'(dhh_r) <<< (2 * DH)) + (SQW'(dhl_r) <<< (DH + 1))
                  + $signed(SQW'(dll_r));

      // s8
      nsq8_r    <= nsq7_r;
      num8_r[0] <= num0_7_r;
      num8_r[1] <= num1_7_r;
      num8_r[2] <= num2_7_r;
    end
  end

  // tolerance tests on the s7 registers
  always_comb begin
    slk[0]   = (SLW'(num0_7_r) <<< EW) + $signed({1'b0, iens_r});
    slk[1]   = (SLW'(num1_7_r) <<< EW) + $signed({1'b0, iens_r});
    slk[2]   = (SLW'(num2_7_r) <<< EW) + $signed({1'b0, iens_r});
    degen    = (CMPW'(nsq7_r[SW-1:0]) << E2W) <= rhs_d_r;
    offplane = dsq_r[CMPW-1:0] > rhs_p_r;
    tag_nxt.vld    = vld_r[FRONT_LAT-2];
    tag_nxt.status = degen ? ST_DEGEN : (offplane ? ST_OFFPLANE : ST_OK);
    tag_nxt.in_tri = !degen && !offplane &&
                     !slk[0][SLW-1] && !slk[1][SLW-1] && !slk[2][SLW-1];
  end

  assign tag = tag_r;
  assign nsq = nsq8_r;
  assign num = num8_r;

endmodule

FILE: rtl/core/pitb_div.sv
// ----------------------------------------------------------------------------
// pitb_div
// Pipelined restoring divider: rounded, saturated weight num / nsq in Q7.16
// ----------------------------------------------------------------------------
module pitb_div import pitb_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  wide_t   num,
  input  wide_t   nsq,
  output weight_t weight
);

  logic          neg_a_r, neg_b_r;
  logic [SW-1:0] mag_a_r, nsq_a_r, nsq_b_r;
  logic [RW-1:0] n_b_r;

  logic [RW-1:0] rem_r [QB];
  logic [SW-1:0] dnsq_r [QB];
  logic [QB-1:0] q_r [QB+1];
  logic          sat_r [QB+1];
  logic          neg_r [QB+1];
  weight_t       weight_r;
  weight_t       qmag;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r   <= num[SW-1];
      mag_a_r   <= num[SW-1] ? -num : num;
      nsq_a_r   <= nsq;
      neg_b_r   <= neg_a_r;
      nsq_b_r   <= nsq_a_r;
      n_b_r     <= (RW'(mag_a_r) << (FRAC + 1)) + RW'(nsq_a_r);
      sat_r[0]  <= n_b_r >= (RW'(nsq_b_r) << (QB + 1));
      neg_r[0]  <= neg_b_r;
      rem_r[0]  <= n_b_r;
      dnsq_r[0] <= nsq_b_r;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(dnsq_r[k-1]) << (QB - k + 1);
    assign take = rem_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= take ? (q_r[k-1] | (QB'(1) << (QB - k))) : q_r[k-1];
        sat_r[k] <= sat_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= take ? rem_r[k-1] - dsh : rem_r[k-1];
          dnsq_r[k] <= dnsq_r[k-1];
        end
      end
    end
  end

  assign qmag = {1'b0, q_r[QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat_r[QB]) begin
        weight_r <= neg_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else begin
        weight_r <= neg_r[QB] ? -qmag : qmag;
      end
    end
  end

  assign weight = weight_r;

endmodule

FILE: rtl/core/point_in_triangle_barycentric_3d_top.sv
// ----------------------------------------------------------------------------
// point_in_triangle_barycentric_3d_top
// Barycentric point-in-triangle test in 3D with tolerance registers
// ----------------------------------------------------------------------------
//  channel  ports               direction  transfer
//  in       in_valid/in_ready   in         query point and three vertices
//  out      out_valid/out_ready out        status, inside flag, three weights
//  cfg      cfg_we              in         one register write per cycle
//
// one item per cycle while the pipeline is not held; a result passes through
// 8 geometry stages, 27 divider stages and the output register
// the output register plus one skid entry keep the pipeline moving while a
// result waits; the whole pipeline holds only once the skid entry is full
// synchronous active-low reset clears valid bits and tolerance registers
// ----------------------------------------------------------------------------
module point_in_triangle_barycentric_3d_top import pitb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  coord_t               in_point_x,
  input  coord_t               in_point_y,
  input  coord_t               in_point_z,
  input  coord_t               in_vertex_a_x,
  input  coord_t               in_vertex_a_y,
  input  coord_t               in_vertex_a_z,
  input  coord_t               in_vertex_b_x,
  input  coord_t               in_vertex_b_y,
  input  coord_t               in_vertex_b_z,
  input  coord_t               in_vertex_c_x,
  input  coord_t               in_vertex_c_y,
  input  coord_t               in_vertex_c_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic                 out_inside_res,
  output weight_t              out_weight_a,
  output weight_t              out_weight_b,
  output weight_t              out_weight_c
);

  eps_t    deg_eps_r, plane_eps_r, inside_eps_r;
  logic    en;
  coord_t  pt [3], va [3], vb [3], vc [3];
  tag_t    f_tag;
  wide_t   f_num [3];
  wide_t   f_nsq;
  weight_t w [3];
  tag_t    meta_r [DIV_LAT];
  tag_t    last;
  res_t    res_nxt, out_r, skid_r;
  logic    out_v_r, skid_v_r;

  // tolerance registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_eps_r    <= '0;
      plane_eps_r  <= '0;
      inside_eps_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGEN_EPS:  deg_eps_r    <= cfg_wdata;
        REG_PLANE_EPS:  plane_eps_r  <= cfg_wdata;
        REG_INSIDE_EPS: inside_eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_r;
  assign in_ready = en;

  assign pt[0] = in_point_x;    assign pt[1] = in_point_y;    assign pt[2] = in_point_z;
  assign va[0] = in_vertex_a_x; assign va[1] = in_vertex_a_y; assign va[2] = in_vertex_a_z;
  assign vb[0] = in_vertex_b_x; assign vb[1] = in_vertex_b_y; assign vb[2] = in_vertex_b_z;
  assign vc[0] = in_vertex_c_x; assign vc[1] = in_vertex_c_y; assign vc[2] = in_vertex_c_z;

  pitb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_valid),
    .pt         (pt),
    .va         (va),
    .vb         (vb),
    .vc         (vc),
    .deg_eps    (deg_eps_r),
    .plane_eps  (plane_eps_r),
    .inside_eps (inside_eps_r),
    .tag        (f_tag),
    .num        (f_num),
    .nsq        (f_nsq)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    pitb_div u_div (
      .clk    (clk),
      .en     (en),
      .num    (f_num[k]),
      .nsq    (f_nsq),
      .weight (w[k])
    );
  end

  // status and valid travel beside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) meta_r[i] <= '0;
    end else if (en) begin
      meta_r[0] <= f_tag;
      for (int i = 1; i < DIV_LAT; i++) meta_r[i] <= meta_r[i-1];
    end
  end

  assign last = meta_r[DIV_LAT-1];

  always_comb begin
    res_nxt.status = last.status;
    res_nxt.in_tri = last.in_tri;
    res_nxt.wa     = (last.status == ST_OK) ? w[0] : '0;
    res_nxt.wb     = (last.status == ST_OK) ? w[1] : '0;
    res_nxt.wc     = (last.status == ST_OK) ? w[2] : '0;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ready) begin
      out_v_r <= last.vld;
    end else if (last.vld) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (!out_v_r || out_ready) begin
      if (last.vld) begin
        out_r <= res_nxt;
      end
    end else if (last.vld) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_status     = out_r.status;
  assign out_inside_res = out_r.in_tri;
  assign out_weight_a   = out_r.wa;
  assign out_weight_b   = out_r.wb;
  assign out_weight_c   = out_r.wc;

endmodule
